@@ hdl/fwh_pkg.sv @@
package fwh_pkg;

	// Input item opcodes
	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} fwh_op_t;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 2'd2;

	// Register reset values
	localparam logic signed [31:0] RANGE_LOW_RST = 32'sd0;
	localparam logic [30:0]        BIN_WIDTH_RST = 31'd65536;
	localparam logic [8:0]         BIN_COUNT_RST = 9'd10;

	typedef struct packed {
		fwh_op_t            op;
		logic signed [31:0] sample;
		logic [7:0]         bin_select;
	} fwh_in_t;

	typedef struct packed {
		logic [7:0]  bin_index;
		logic        in_range;
		logic [31:0] bin_value;
	} fwh_out_t;

	typedef struct packed {
		logic signed [31:0] range_low;
		logic [30:0]        bin_width;
		logic [8:0]         bin_count;
	} fwh_cfg_t;

	// Work handed from the classifier to the bin store
	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_UPDATE,
		CMD_READ,
		CMD_CLEAR
	} fwh_kind_t;

	typedef struct packed {
		fwh_kind_t  kind;
		logic [7:0] bin_index;
		logic       in_range;
	} fwh_cmd_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CHECK,
		F_DIV,
		F_PUSH
	} fwh_fstate_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_MEM
	} fwh_bstate_t;

endpackage

@@ hdl/fwh_ram.sv @@
module fwh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/fwh_queue.sv @@
module fwh_queue #(
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	// two-entry ring
	logic [WIDTH-1:0] ent_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

endmodule

@@ hdl/fwh_front.sv @@
module fwh_front #(
	parameter int MAX_BINS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fwh_pkg::fwh_cfg_t           cfg,
	input  logic                        cmd_valid,
	input  fwh_pkg::fwh_in_t            cmd,
	output logic                        cmd_stall,
	input  logic                        clearing,
	input  logic                        q_full,
	output logic                        push,
	output fwh_pkg::fwh_cmd_t           push_cmd,
	output logic [$clog2(MAX_BINS)-1:0] push_addr
);
	import fwh_pkg::*;

	localparam int AW    = $clog2(MAX_BINS);
	localparam int DW    = 31 + AW;
	localparam int CNT_W = $clog2(AW + 1);

	fwh_fstate_t        state_q, state_d;
	fwh_op_t            op_q;
	logic [7:0]         sel_q;
	logic signed [32:0] diff_q;
	logic [31:0]        rem_q;
	logic [DW-1:0]      dvs_q;
	logic [AW-1:0]      quo_q;
	logic [CNT_W-1:0]   cnt_q;
	fwh_cmd_t           cmd_q;
	logic [AW-1:0]      addr_q;

	logic          accept;
	logic          sel_ok;
	logic [AW+7:0] sel_x;
	logic [AW-1:0] sel_addr;
	logic [DW-1:0] lim;
	logic          reject;
	logic          take;
	logic [AW-1:0] quo_nx;
	logic [AW+7:0] quo_x;
	logic          used_ok;
	logic          last;

	assign cmd_stall = (state_q != F_IDLE) || clearing;
	assign accept    = cmd_valid && !cmd_stall;

	// bin select checks
	assign sel_ok   = 32'(sel_q) < 32'(MAX_BINS);
	assign sel_x    = {{AW{1'b0}}, sel_q};
	assign sel_addr = sel_x[AW-1:0];

	// quotient >= 2^AW can never be a bin in use
	assign lim    = DW'(cfg.bin_width) << AW;
	assign reject = diff_q[32] || (cfg.bin_width == '0) || (DW'(diff_q[31:0]) >= lim);

	// one restoring division step per cycle
	assign take    = DW'(rem_q) >= dvs_q;
	assign quo_nx  = AW'(quo_q << 1) | AW'(take);
	assign quo_x   = {8'd0, quo_nx};
	assign used_ok = (32'(quo_nx) < 32'(cfg.bin_count)) && (32'(quo_nx) < 32'(MAX_BINS));
	assign last    = (cnt_q == CNT_W'(AW - 1));

	assign push      = (state_q == F_PUSH) && !q_full;
	assign push_cmd  = cmd_q;
	assign push_addr = addr_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept) state_d = F_CHECK;
			end
			F_CHECK: begin
				if (op_q == OP_ADD && !reject) state_d = F_DIV;
				else                           state_d = F_PUSH;
			end
			F_DIV: begin
				if (last) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= cmd.op;
			sel_q  <= cmd.bin_select;
			diff_q <= 33'(cmd.sample) - 33'(cfg.range_low);
		end
		if (state_q == F_CHECK) begin
			rem_q  <= diff_q[31:0];
			dvs_q  <= DW'(cfg.bin_width) << (AW - 1);
			quo_q  <= '0;
			cnt_q  <= '0;
			addr_q <= sel_addr;
			unique case (op_q)
				OP_ADD: begin
					cmd_q <= '{kind: CMD_NONE, bin_index: 8'd0, in_range: 1'b0};
				end
				OP_READ: begin
					cmd_q <= '{kind: (sel_ok ? CMD_READ : CMD_NONE),
						bin_index: sel_q, in_range: 1'b0};
				end
				OP_CLEAR: begin
					cmd_q <= '{kind: (sel_ok ? CMD_CLEAR : CMD_NONE),
						bin_index: sel_q, in_range: 1'b0};
				end
				OP_NONE: begin
					cmd_q <= '{kind: CMD_NONE, bin_index: sel_q, in_range: 1'b0};
				end
				default: begin
					cmd_q <= '{kind: CMD_NONE, bin_index: sel_q, in_range: 1'b0};
				end
			endcase
		end
		if (state_q == F_DIV) begin
			if (take) rem_q <= rem_q - dvs_q[31:0];
			dvs_q <= dvs_q >> 1;
			quo_q <= quo_nx;
			cnt_q <= CNT_W'(cnt_q + 1'b1);
			if (last) begin
				addr_q <= quo_nx;
				if (used_ok) begin
					cmd_q <= '{kind: CMD_UPDATE, bin_index: quo_x[7:0], in_range: 1'b1};
				end else begin
					cmd_q <= '{kind: CMD_NONE, bin_index: 8'd0, in_range: 1'b0};
				end
			end
		end
	end

endmodule

@@ hdl/fwh_back.sv @@
module fwh_back #(
	parameter int MAX_BINS    = 256,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  fwh_pkg::fwh_cmd_t           head_cmd,
	input  logic [$clog2(MAX_BINS)-1:0] head_addr,
	output logic                        pop,
	output logic                        clearing,
	output logic                        res_valid,
	input  logic                        res_stall,
	output fwh_pkg::fwh_out_t           res
);
	import fwh_pkg::*;

	localparam int AW = $clog2(MAX_BINS);
	localparam int CW = COUNT_WIDTH;

	fwh_bstate_t state_q, state_d;
	logic [AW-1:0] clr_q;
	fwh_kind_t     kind_q;
	logic [7:0]    idx_q;
	logic          inr_q;
	logic [AW-1:0] addr_q;
	logic          res_valid_q;
	fwh_out_t      res_q;

	logic          out_free;
	logic          we;
	logic [AW-1:0] waddr;
	logic [CW-1:0] wdata;
	logic [CW-1:0] rdata;
	logic [CW-1:0] inc;
	logic [CW-1:0] cnt_sel;
	logic [CW+31:0] cnt_x;
	logic          load;
	fwh_out_t      load_data;

	fwh_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_BINS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (head_addr),
		.rdata (rdata)
	);

	assign out_free  = !res_valid_q || !res_stall;
	assign pop       = (state_q == B_IDLE) && !q_empty && out_free;
	assign clearing  = (state_q == B_CLEAR);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// saturating increment, result shown as its low 32 bits
	assign inc     = (rdata == '1) ? rdata : CW'(rdata + 1'b1);
	assign cnt_sel = (kind_q == CMD_UPDATE) ? inc : rdata;
	assign cnt_x   = {32'd0, cnt_sel};

	// next state, store port and result load
	always_comb begin
		state_d   = state_q;
		we        = 1'b0;
		waddr     = head_addr;
		wdata     = '0;
		load      = 1'b0;
		load_data = '{bin_index: head_cmd.bin_index, in_range: head_cmd.in_range,
			bin_value: 32'd0};
		unique case (state_q)
			B_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				if (clr_q == AW'(MAX_BINS - 1)) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (pop) begin
					if (head_cmd.kind == CMD_READ || head_cmd.kind == CMD_UPDATE) begin
						state_d = B_MEM;
					end else begin
						load = 1'b1;
						we   = (head_cmd.kind == CMD_CLEAR);
					end
				end
			end
			B_MEM: begin
				we        = (kind_q == CMD_UPDATE);
				waddr     = addr_q;
				wdata     = inc;
				load      = 1'b1;
				load_data = '{bin_index: idx_q, in_range: inr_q, bin_value: cnt_x[31:0]};
				state_d   = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) clr_q <= AW'(clr_q + 1'b1);
			if (load)            res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= head_cmd.kind;
			idx_q  <= head_cmd.bin_index;
			inr_q  <= head_cmd.in_range;
			addr_q <= head_addr;
		end
		if (load) res_q <= load_data;
	end

endmodule

@@ hdl/fixed_width_histogram.sv @@
// Fixed bin width histogram engine.
// Each item passes the classifier (a check, the divider for samples not rejected up front,
// then a push), the two-entry queue and the bin store, where reads and updates first read the store.
// The classifier takes a new item only once the previous one has been pushed to the queue.
// Reset: asynchronous; afterwards a clearing pass writes zero to all MAX_BINS bins of the store
// while the input stays stalled. Registers return to range_low 0, bin_width 1.0, bin_count 10.
module fixed_width_histogram #(
	parameter int MAX_BINS    = 256,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fwh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fwh_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  fwh_pkg::fwh_in_t                    cmd,
	output logic                                res_valid,
	input  logic                                res_stall,
	output fwh_pkg::fwh_out_t                   res
);
	import fwh_pkg::*;

	localparam int AW   = $clog2(MAX_BINS);
	localparam int QW   = $bits(fwh_cmd_t) + AW;

	fwh_cfg_t      cfg_q;
	logic          clearing;
	logic          q_full;
	logic          q_empty;
	logic          push;
	logic          pop;
	fwh_cmd_t      push_cmd;
	logic [AW-1:0] push_addr;
	logic [QW-1:0] head;
	fwh_cmd_t      head_cmd;
	logic [AW-1:0] head_addr;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_low <= RANGE_LOW_RST;
			cfg_q.bin_width <= BIN_WIDTH_RST;
			cfg_q.bin_count <= BIN_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RANGE_LOW: cfg_q.range_low <= cfg_data;
				CFG_BIN_WIDTH: cfg_q.bin_width <= cfg_data[30:0];
				CFG_BIN_COUNT: cfg_q.bin_count <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	fwh_front #(
		.MAX_BINS (MAX_BINS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_stall (cmd_stall),
		.clearing  (clearing),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_addr (push_addr)
	);

	fwh_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_cmd, push_addr}),
		.pop       (pop),
		.pop_data  (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	assign head_cmd  = head[QW-1:AW];
	assign head_addr = head[AW-1:0];

	fwh_back #(
		.MAX_BINS    (MAX_BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head_cmd  (head_cmd),
		.head_addr (head_addr),
		.pop       (pop),
		.clearing  (clearing),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

@@ hdl/fwh_checker.sv @@
module fwh_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_stall,
	input logic              res_valid,
	input logic              res_stall,
	input fwh_pkg::fwh_out_t res
);
	import fwh_pkg::*;

	logic       cmd_acc;
	logic       res_acc;
	logic [2:0] open_q;

	assign cmd_acc = cmd_valid && !cmd_stall;
	assign res_acc = res_valid && !res_stall;

	// items accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 3'd0;
		end else if (cmd_acc && !res_acc) begin
			open_q <= open_q + 3'd1;
		end else if (res_acc && !cmd_acc) begin
			open_q <= open_q - 3'd1;
		end
	end

	// a held result keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// no result without an open item
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> open_q != 3'd0)
		else $error("result with no item outstanding");

	// classifier, queue and output stage hold at most four items
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 3'd4)
		else $error("too many items in flight");

	// classifier works on one item at a time
	a_one_front: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> cmd_stall)
		else $error("item accepted while classifier busy");

	// store clearing pass blocks input right after reset
	a_clear_pass: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> cmd_stall)
		else $error("input open before bin store cleared");

endmodule

bind fixed_width_histogram fwh_checker u_fwh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
